[rtl/core/task_dag_edge_insert_cycle_check_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the task graph block checker
// Clock is clock, synchronous reset is reset; both come from the checker ports.
// ----------------------------------------------------------------------------
`ifndef TASK_DAG_EDGE_INSERT_CYCLE_CHECK_TOP_DEFINES_SVH
`define TASK_DAG_EDGE_INSERT_CYCLE_CHECK_TOP_DEFINES_SVH

// Same-cycle implication.
`define TDEC_ASSERT_IMPL(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication.
`define TDEC_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

[rtl/core/tdec_pkg.sv]
// ----------------------------------------------------------------------------
// tdec_pkg
// Transaction types and status codes of the task graph edge insertion block.
// ----------------------------------------------------------------------------
package tdec_pkg;

   // Request kinds
   localparam logic REQ_ADD_TASK = 1'b0;
   localparam logic REQ_ADD_EDGE = 1'b1;

   // Status codes
   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_NO_TASK   = 3'd1;
   localparam logic [2:0] STATUS_SELF_DEP  = 3'd2;
   localparam logic [2:0] STATUS_DUPLICATE = 3'd3;
   localparam logic [2:0] STATUS_CYCLE     = 3'd4;

   typedef struct packed {
      logic       req_type;
      logic [7:0] pred_id;    // task that must finish first
      logic [7:0] succ_id;    // task that waits on it
   } req_item_type;

   typedef struct packed {
      logic [2:0] status;
      logic [6:0] task_id;    // id handed to a new task
   } rsp_item_type;

endpackage

[rtl/core/tdec_ram.sv]
// ----------------------------------------------------------------------------
// tdec_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tdec_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/task_dag_edge_insert_cycle_check_top.sv]
// ----------------------------------------------------------------------------
// task_dag_edge_insert_cycle_check_top: task graph with cycle-checked edges
// Result paths: add-task/bad id/self dep from idle; dup after row read; else pick/expand search
// Throughput: one transaction at a time, busy until the result strobe; no output stall.
// Reset: sync; clears count, live set, FSM, strobe; edge RAM rows zeroed per added task.
// ----------------------------------------------------------------------------
module task_dag_edge_insert_cycle_check_top #(
   parameter int NODES = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  tdec_pkg::req_item_type  req,
   output logic                    rsp_valid,
   output tdec_pkg::rsp_item_type  rsp
);

   // Address of one adjacency row / index of one node
   localparam int ADDR_W = (NODES > 1) ? $clog2(NODES) : 1;
   // Task count holds 0..NODES
   localparam int CNT_W  = $clog2(NODES + 1);
   // Common width for comparing 8-bit ids against the count
   localparam int IDX_W  = (CNT_W > 8) ? CNT_W : 8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DUP,     // row of dependency arrives, check for existing edge
      ST_PICK,    // choose next pending node, or finish with no path
      ST_EXPAND   // row of picked node arrives, grow reached set
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [NODES-1:0]        live_ff, live_in;      // tasks that exist
   logic [NODES-1:0]        seen_ff, seen_in;      // nodes reached from dependent
   logic [NODES-1:0]        pend_ff, pend_in;      // reached, row not yet read
   logic [NODES-1:0]        dep_row_ff, dep_row_in;
   logic [ADDR_W-1:0]       dep_addr_ff, dep_addr_in;
   logic [ADDR_W-1:0]       dnt_addr_ff, dnt_addr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   tdec_pkg::rsp_item_type  rsp_ff, rsp_in;

   // Edge RAM port signals
   logic                    ram_we;
   logic [ADDR_W-1:0]       ram_waddr;
   logic [NODES-1:0]        ram_wdata;
   logic                    ram_re;
   logic [ADDR_W-1:0]       ram_raddr;
   logic [NODES-1:0]        ram_rdata;

   // Request decode
   logic [IDX_W-1:0]        dep_ext, dnt_ext, cnt_ext;
   logic [CNT_W-1:0]        cnt_inc;
   logic                    dep_bad, dnt_bad;
   logic [NODES-1:0]        fresh;
   logic [NODES-1:0]        dnt_bit;
   logic [ADDR_W-1:0]       pick_addr;

   // Lowest pending node
   function automatic logic [ADDR_W-1:0] first_set(input logic [NODES-1:0] v);
      logic [ADDR_W-1:0] idx;
      idx = '0;
      for (int i = NODES - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = ADDR_W'(i);
         end
      end
      return idx;
   endfunction

   tdec_ram #(
      .WIDTH (NODES),
      .DEPTH (NODES)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign dep_ext   = IDX_W'(req.pred_id);
   assign dnt_ext   = IDX_W'(req.succ_id);
   assign cnt_ext   = IDX_W'(count_ff);
   assign cnt_inc   = count_ff + CNT_W'(1);
   // Ids are 1-based; 0 or above the count is no task
   assign dep_bad   = (dep_ext == '0) || (dep_ext > cnt_ext);
   assign dnt_bad   = (dnt_ext == '0) || (dnt_ext > cnt_ext);
   // Newly reached nodes; only existing tasks count
   assign fresh     = ram_rdata & ~seen_ff & live_ff;
   assign pick_addr = first_set(pend_ff);

   always_comb begin
      dnt_bit              = '0;
      dnt_bit[dnt_addr_ff] = 1'b1;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      live_in      = live_ff;
      seen_in      = seen_ff;
      pend_in      = pend_ff;
      dep_row_in   = dep_row_ff;
      dep_addr_in  = dep_addr_ff;
      dnt_addr_in  = dnt_addr_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = count_ff[ADDR_W-1:0];
      ram_wdata    = '0;
      ram_re       = 1'b0;
      ram_raddr    = pick_addr;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rsp_in.task_id = '0;
               if (req.req_type == tdec_pkg::REQ_ADD_TASK) begin
                  rsp_valid_in = 1'b1;
                  if (count_ff == CNT_W'(NODES)) begin
                     rsp_in.status = tdec_pkg::STATUS_CYCLE;
                  end else begin
                     // clear the new task's row
                     ram_we                          = 1'b1;
                     ram_waddr                       = count_ff[ADDR_W-1:0];
                     ram_wdata                       = '0;
                     live_in[count_ff[ADDR_W-1:0]]   = 1'b1;
                     count_in                        = cnt_inc;
                     rsp_in.status                   = tdec_pkg::STATUS_OK;
                     rsp_in.task_id                  = 7'(cnt_inc);
                  end
               end else if (dep_bad || dnt_bad) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = tdec_pkg::STATUS_NO_TASK;
               end else if (dep_ext == dnt_ext) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = tdec_pkg::STATUS_SELF_DEP;
               end else begin
                  dep_addr_in = ADDR_W'(dep_ext - IDX_W'(1));
                  dnt_addr_in = ADDR_W'(dnt_ext - IDX_W'(1));
                  ram_re      = 1'b1;
                  ram_raddr   = ADDR_W'(dep_ext - IDX_W'(1));
                  state_in    = ST_DUP;
               end
            end
         end

         ST_DUP: begin
            if (ram_rdata[dnt_addr_ff]) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = tdec_pkg::STATUS_DUPLICATE;
               state_in      = ST_IDLE;
            end else begin
               // search starts at the dependent
               dep_row_in = ram_rdata;
               seen_in    = dnt_bit;
               pend_in    = dnt_bit;
               state_in   = ST_PICK;
            end
         end

         ST_PICK: begin
            if (pend_ff == '0) begin
               // no path back: record the edge
               ram_we        = 1'b1;
               ram_waddr     = dep_addr_ff;
               ram_wdata     = dep_row_ff | dnt_bit;
               rsp_valid_in  = 1'b1;
               rsp_in.status = tdec_pkg::STATUS_OK;
               state_in      = ST_IDLE;
            end else begin
               ram_re              = 1'b1;
               ram_raddr           = pick_addr;
               pend_in[pick_addr]  = 1'b0;
               state_in            = ST_EXPAND;
            end
         end

         ST_EXPAND: begin
            if (fresh[dep_addr_ff]) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = tdec_pkg::STATUS_CYCLE;
               state_in      = ST_IDLE;
            end else begin
               seen_in  = seen_ff | fresh;
               pend_in  = pend_ff | fresh;
               state_in = ST_PICK;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      seen_ff     <= seen_in;
      pend_ff     <= pend_in;
      dep_row_ff  <= dep_row_in;
      dep_addr_ff <= dep_addr_in;
      dnt_addr_ff <= dnt_addr_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

[rtl/core/tdec_checker.sv]
// ----------------------------------------------------------------------------
// tdec_checker
// Port-level checks of the task graph block, bound to the top level.
// ----------------------------------------------------------------------------
`include "task_dag_edge_insert_cycle_check_top_defines.svh"

module tdec_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input tdec_pkg::req_item_type req,
   input logic                   rsp_valid,
   input tdec_pkg::rsp_item_type rsp
);

   logic id_given;
   logic status_ok;

   assign id_given  = rsp_valid && (rsp.task_id != '0);
   assign status_ok = (rsp.status == tdec_pkg::STATUS_OK);

   // an accepted transaction either answers at once or keeps the block busy
   `TDEC_ASSERT_NEXT(a_accept_progress, start && !busy, rsp_valid || busy, "accept lost")
   // the result comes with the block going idle
   `TDEC_ASSERT_IMPL(a_rsp_idle, rsp_valid, !busy, "result while busy")
   // finishing a search always delivers a result
   `TDEC_ASSERT_IMPL(a_done_rsp, $fell(busy) && !$past(reset), rsp_valid, "search ended silently")
   // an id is only handed out on success
   `TDEC_ASSERT_IMPL(a_id_ok, id_given, status_ok, "id with error status")

endmodule

bind task_dag_edge_insert_cycle_check_top tdec_checker u_tdec_checker (.*);
